// ----- rtl/kwm_pkg.sv -----
// Shared constants and types for the command line keyword matcher.
package kwm_pkg;

	localparam int REG_SLOTS      = 7;
	localparam int NAME_SLOTS_DEF = 7;
	localparam int NAME_BYTES_DEF = 8;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 3;
	localparam int MAX_LEN_W      = 8;
	localparam int LINE_LEN_W     = 9;
	localparam int SYM_W          = 8;
	localparam int SLOT_W         = 3;

	localparam logic [SYM_W-1:0] SYM_NEWLINE = 8'h0A;
	localparam logic [SYM_W-1:0] SYM_RETURN  = 8'h0D;
	localparam logic [SYM_W-1:0] SYM_SPACE   = 8'h20;

	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 8'd64;

	// register indexes on the config port
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_BASE = 3'd1;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_MATCH    = 2'd1,
		ST_UNKNOWN  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
	} result_t;

endpackage

// ----- rtl/kwm_if.sv -----
// Handshake channels: received symbols in, match results out.
interface kwm_sym_if;
	logic                     valid;
	logic                     ready;
	logic [kwm_pkg::SYM_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink   (input valid, input symbol, output ready);
endinterface

interface kwm_res_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [kwm_pkg::SLOT_W-1:0] matched_slot;

	modport source (output valid, output status, output matched_slot, input ready);
	modport sink   (input valid, input status, input matched_slot, output ready);
endinterface

// ----- rtl/kwm_cfg.sv -----
// Configuration registers: maximum line length and the command name slots.
module kwm_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [kwm_pkg::CFG_INDEX_W-1:0]   index,
	input  logic [kwm_pkg::CFG_DATA_W-1:0]    data,
	output logic [kwm_pkg::MAX_LEN_W-1:0]     max_len,
	output logic [kwm_pkg::CFG_DATA_W-1:0]    names [kwm_pkg::REG_SLOTS]
);

	logic [kwm_pkg::MAX_LEN_W-1:0]  max_len_q;
	logic [kwm_pkg::CFG_DATA_W-1:0] names_q [kwm_pkg::REG_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= kwm_pkg::MAX_LEN_RESET;
			for (int i = 0; i < kwm_pkg::REG_SLOTS; i++) begin
				names_q[i] <= '0;
			end
		end else if (we) begin
			if (index == kwm_pkg::REG_MAX_LEN) begin
				max_len_q <= data[kwm_pkg::MAX_LEN_W-1:0];
			end else begin
				names_q[kwm_pkg::CFG_INDEX_W'(index - kwm_pkg::REG_NAME_BASE)] <= data;
			end
		end
	end

	assign max_len = max_len_q;
	assign names   = names_q;

endmodule

// ----- rtl/kwm_line.sv -----
// Line state and per-symbol compare against all name slots in one pass.
module kwm_line #(
	parameter int NAME_SLOTS = kwm_pkg::NAME_SLOTS_DEF,
	parameter int NAME_BYTES = kwm_pkg::NAME_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [kwm_pkg::SYM_W-1:0]     sym,
	input  logic [kwm_pkg::MAX_LEN_W-1:0] max_len,
	input  logic [kwm_pkg::CFG_DATA_W-1:0] names [kwm_pkg::REG_SLOTS],
	output kwm_pkg::result_t              res
);

	localparam int TOK_W = $clog2(NAME_BYTES + 2);
	localparam logic [TOK_W-1:0] TOK_FULL = TOK_W'(NAME_BYTES);
	localparam logic [TOK_W-1:0] TOK_SAT  = TOK_W'(NAME_BYTES + 1);
	localparam logic [kwm_pkg::LINE_LEN_W-1:0] LINE_SAT = '1;

	logic [kwm_pkg::LINE_LEN_W-1:0] line_len_q, line_len_n;
	logic [TOK_W-1:0]               tok_len_q, tok_len_n;
	logic                           tok_done_q, tok_done_n;
	logic [NAME_SLOTS-1:0]          still_q, still_n;

	logic [kwm_pkg::SYM_W-1:0] cur_byte [NAME_SLOTS];
	logic [NAME_SLOTS-1:0]     hit;
	logic [NAME_SLOTS-1:0]     keep;
	logic                      tl_in_name;
	logic                      found;
	logic [kwm_pkg::SLOT_W-1:0] first_hit;
	logic                      too_long;

	assign tl_in_name = tok_len_q < TOK_FULL;
	assign too_long   = {1'b0, max_len} < line_len_q;

	// name byte at the current token position, per slot
	always_comb begin
		for (int s = 0; s < NAME_SLOTS; s++) begin
			cur_byte[s] = '0;
			for (int p = 0; p < NAME_BYTES; p++) begin
				if (tok_len_q == TOK_W'(p)) begin
					cur_byte[s] = names[s][8*p +: 8];
				end
			end
			keep[s] = tl_in_name && (sym != '0) && (cur_byte[s] == sym);
			hit[s]  = still_q[s] && (tok_len_q != '0) &&
				((tok_len_q == TOK_FULL) || (tl_in_name && (cur_byte[s] == '0)));
		end
	end

	// lowest matching slot wins
	always_comb begin
		found     = 1'b0;
		first_hit = '0;
		for (int s = NAME_SLOTS - 1; s >= 0; s--) begin
			if (hit[s]) begin
				found     = 1'b1;
				first_hit = kwm_pkg::SLOT_W'(s);
			end
		end
	end

	always_comb begin
		line_len_n = line_len_q;
		tok_len_n  = tok_len_q;
		tok_done_n = tok_done_q;
		still_n    = still_q;
		res.status = kwm_pkg::ST_BUSY;
		res.slot   = '0;
		if (sym == kwm_pkg::SYM_NEWLINE) begin
			res.status = found ? kwm_pkg::ST_MATCH : kwm_pkg::ST_UNKNOWN;
			res.slot   = found ? first_hit : '0;
			line_len_n = '0;
			tok_len_n  = '0;
			tok_done_n = 1'b0;
			still_n    = '1;
		end else if (too_long) begin
			res.status = kwm_pkg::ST_TOO_LONG;
			line_len_n = '0;
			tok_len_n  = '0;
			tok_done_n = 1'b0;
			still_n    = '1;
		end else if (sym != kwm_pkg::SYM_RETURN) begin
			if (!tok_done_q) begin
				if (sym == kwm_pkg::SYM_SPACE) begin
					tok_done_n = 1'b1;
				end else begin
					still_n = still_q & keep;
					if (tok_len_q < TOK_SAT) begin
						tok_len_n = tok_len_q + 1'b1;
					end
				end
			end
			if (line_len_q != LINE_SAT) begin
				line_len_n = line_len_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			tok_len_q  <= '0;
			tok_done_q <= 1'b0;
			still_q    <= '1;
		end else if (go) begin
			line_len_q <= line_len_n;
			tok_len_q  <= tok_len_n;
			tok_done_q <= tok_done_n;
			still_q    <= still_n;
		end
	end

endmodule

// ----- rtl/command_line_keyword_matcher.sv -----
// Top level of the command line keyword matcher.
//
// Usage: one received character per request on the sym channel (valid/ready,
// payload symbol). Every request produces exactly one result on the res
// channel: status (busy, matched, unknown command, line too long) and
// matched_slot (lowest matching name slot when matched, else zero).
// Names and the maximum line length are written through the plain config
// port (cfg_we/cfg_index/cfg_data) while no request is in flight.
//
// Timing: a request taken into the input stage is compared against all
// name slots in one pass and then lands in the result register.
// Throughput is one request per cycle while res.ready is high; the line state
// update is combinational: consecutive characters never wait on each other.
//
// Stall: the result register holds its request until res.ready; meanwhile one
// more character can wait in the input stage, after which sym.ready drops.
//
// Reset (arst_n low): line empty, all slots armed, names cleared,
// maximum line length 64, both stages empty.
module command_line_keyword_matcher #(
	parameter int NAME_SLOTS = kwm_pkg::NAME_SLOTS_DEF,
	parameter int NAME_BYTES = kwm_pkg::NAME_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	kwm_sym_if.sink                          sym,
	kwm_res_if.source                        res,
	input  logic                             cfg_we,
	input  logic [kwm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [kwm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [kwm_pkg::MAX_LEN_W-1:0]  max_len;
	logic [kwm_pkg::CFG_DATA_W-1:0] names [kwm_pkg::REG_SLOTS];

	// input stage
	logic                      valid_s1;
	logic [kwm_pkg::SYM_W-1:0] sym_s1;

	// result stage
	logic              valid_s2;
	kwm_pkg::result_t  res_s2;

	kwm_pkg::result_t  step_res;
	logic              advance;

	// input stage moves on when the result register is free or draining
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign sym.ready = !valid_s1 || advance;

	kwm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (cfg_we),
		.index   (cfg_index),
		.data    (cfg_data),
		.max_len (max_len),
		.names   (names)
	);

	kwm_line #(
		.NAME_SLOTS (NAME_SLOTS),
		.NAME_BYTES (NAME_BYTES)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (advance),
		.sym     (sym_s1),
		.max_len (max_len),
		.names   (names),
		.res     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym.ready) begin
			valid_s1 <= sym.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym.valid && sym.ready) begin
			sym_s1 <= sym.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign res.valid        = valid_s2;
	assign res.status       = res_s2.status;
	assign res.matched_slot = res_s2.slot;

endmodule

// ----- rtl/kwm_checker.sv -----
// Port-level checks for the keyword matcher, bound to the top level.
module kwm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [1:0]                   status,
	input logic [kwm_pkg::SLOT_W-1:0]   matched_slot
);

	localparam logic [kwm_pkg::SLOT_W-1:0] SLOT_LAST = kwm_pkg::SLOT_W'(kwm_pkg::REG_SLOTS - 1);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(matched_slot))
		else $error("result changed while stalled");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != kwm_pkg::ST_MATCH) |-> matched_slot == '0)
		else $error("slot index set without a match");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == kwm_pkg::ST_MATCH) |-> matched_slot <= SLOT_LAST)
		else $error("matched slot out of range");

endmodule

bind command_line_keyword_matcher kwm_checker u_kwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.status       (res.status),
	.matched_slot (res.matched_slot)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the command line keyword matcher.
module tb_top;

	localparam int NAME_SLOTS  = kwm_pkg::NAME_SLOTS_DEF;
	localparam int NAME_BYTES  = kwm_pkg::NAME_BYTES_DEF;
	// cycles with no request, result or register write before the run is called hung
	localparam int STALL_LIMIT = 1000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 175;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [kwm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [kwm_pkg::CFG_DATA_W-1:0] cfg_data;

	kwm_sym_if sym_ch ();
	kwm_res_if res_ch ();

	command_line_keyword_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym       (sym_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Line predictor: a private copy of the registers and the line state.
	// ------------------------------------------------------------------
	logic [kwm_pkg::MAX_LEN_W-1:0] cfg_max_len;
	logic [kwm_pkg::CFG_DATA_W-1:0] cfg_names [kwm_pkg::REG_SLOTS];
	logic [kwm_pkg::LINE_LEN_W-1:0] line_len;
	logic [3:0] tok_len;           // saturates at NAME_BYTES + 1
	logic tok_done;                // a space has closed the first token
	logic [NAME_SLOTS-1:0] still_matching;

	function automatic logic [7:0] name_char(int s, int pos);
		return cfg_names[s][8*pos +: 8];
	endfunction

	function automatic void clear_line();
		line_len = '0;
		tok_len = '0;
		tok_done = 1'b0;
		still_matching = '1;
	endfunction

	// Advances the line state by one received character and returns the
	// status the block must report for it.
	function automatic kwm_pkg::result_t predict_keyword(logic [kwm_pkg::SYM_W-1:0] ch);
		kwm_pkg::result_t r;
		r.status = kwm_pkg::ST_BUSY;
		r.slot = '0;
		if (ch == kwm_pkg::SYM_NEWLINE) begin
			// Newline always closes the line, however long it got.
			r.status = kwm_pkg::ST_UNKNOWN;
			// walk downward so the lowest matching slot is the one left standing
			for (int s = NAME_SLOTS - 1; s >= 0; s--) begin
				if (still_matching[s] && tok_len != 0 && tok_len <= NAME_BYTES &&
						(tok_len == NAME_BYTES || name_char(s, tok_len) == '0)) begin
					r.status = kwm_pkg::ST_MATCH;
					r.slot = 3'(s);
				end
			end
			clear_line();
		end else if (line_len > cfg_max_len) begin
			// Overlong line: dropped on the next non-newline byte, CR included.
			clear_line();
			r.status = kwm_pkg::ST_TOO_LONG;
		end else if (ch != kwm_pkg::SYM_RETURN) begin
			if (!tok_done) begin
				if (ch == kwm_pkg::SYM_SPACE) begin
					tok_done = 1'b1;
				end else begin
					// a zero byte or a token past the name width kills every slot
					for (int s = 0; s < NAME_SLOTS; s++) begin
						if (tok_len >= NAME_BYTES || ch == '0 || name_char(s, tok_len) != ch)
							still_matching[s] = 1'b0;
					end
					if (tok_len <= NAME_BYTES)
						tok_len++;
				end
			end
			if (line_len < {kwm_pkg::LINE_LEN_W{1'b1}})
				line_len++;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: feeds characters from sym_pending with random gaps.
	// ------------------------------------------------------------------
	logic [kwm_pkg::SYM_W-1:0] sym_pending [$];
	kwm_pkg::result_t expected_results [$];
	kwm_pkg::result_t oldest_expected;
	int sym_gap_max;
	int res_gap_max;
	int sym_wait;
	int res_wait;
	logic sym_offer;
	int fail_count;
	int quiet_cycles;

	// append one character to the send queue
	function automatic void add_sym(logic [kwm_pkg::SYM_W-1:0] c);
		sym_pending.insert(sym_pending.size(), c);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			sym_ch.valid <= 1'b0;
			sym_wait = 0;
		end else begin
			if (sym_ch.valid && sym_ch.ready) begin
				// predict at acceptance; registers only change while idle
				expected_results.insert(expected_results.size(),
					predict_keyword(sym_ch.symbol));
				sym_wait = $urandom_range(0, sym_gap_max);
				sym_offer = 1'b0;
			end else begin
				sym_offer = sym_ch.valid;
			end
			if (!sym_offer) begin
				if (sym_wait > 0) begin
					sym_wait--;
				end else if (sym_pending.size() != 0) begin
					sym_ch.symbol <= sym_pending.pop_front();
					sym_offer = 1'b1;
				end
			end
			// single update of valid per edge
			sym_ch.valid <= sym_offer;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random back-pressure, in-order compare.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			res_wait = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: result with nothing pending: status=%0d slot=%0d",
							res_ch.status, res_ch.matched_slot);
				end else begin
					oldest_expected = expected_results.pop_front();
					if (res_ch.status !== oldest_expected.status ||
							res_ch.matched_slot !== oldest_expected.slot) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: expected status=%0d slot=%0d, got status=%0d slot=%0d",
								oldest_expected.status, oldest_expected.slot,
								res_ch.status, res_ch.matched_slot);
					end
				end
				res_wait = $urandom_range(0, res_gap_max);
			end
			if (res_wait > 0) begin
				res_wait--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Hang detector: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sym_ch.valid && sym_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Register write; only called with the block drained.
	task automatic write_reg(input logic [kwm_pkg::CFG_INDEX_W-1:0] idx,
			input logic [kwm_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == kwm_pkg::REG_MAX_LEN)
			cfg_max_len = data[kwm_pkg::MAX_LEN_W-1:0];
		else
			cfg_names[int'(idx) - int'(kwm_pkg::REG_NAME_BASE)] = data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Sender holds off until every queued request has its result back.
	task automatic wait_drained();
		while (sym_pending.size() != 0 || sym_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void queue_text(string t);
		for (int i = 0; i < t.len(); i++)
			add_sym(t[i]);
	endfunction

	// Name character: mostly a tiny alphabet so names collide and share
	// prefixes; otherwise any byte that can sit inside a token.
	function automatic logic [7:0] name_symbol();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0)
			return 8'("a") + 8'($urandom_range(0, 3));
		do
			c = 8'($urandom_range(1, 255));
		while (c == kwm_pkg::SYM_NEWLINE || c == kwm_pkg::SYM_RETURN ||
			c == kwm_pkg::SYM_SPACE);
		return c;
	endfunction

	function automatic logic [kwm_pkg::CFG_DATA_W-1:0] make_name();
		logic [kwm_pkg::CFG_DATA_W-1:0] n;
		int pick;
		int len;
		n = '0;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;                      // unused slot
		if (pick == 1)
			return '1;                      // eight 0xFF bytes
		if (pick == 2)
			return {$urandom, $urandom};    // raw bits, bytes after a zero are ignored
		len = $urandom_range(1, NAME_BYTES);
		if (pick <= 6) begin
			// duplicate or prefix of another slot
			n = cfg_names[$urandom_range(0, NAME_SLOTS - 1)];
			return n & ((64'h1 << (8 * len)) - 1);
		end
		for (int i = 0; i < len; i++)
			n[8*i +: 8] = name_symbol();
		return n;
	endfunction

	// One command line, mostly built from a configured name with an
	// occasional defect, else a random token or raw noise.
	function automatic void queue_line();
		logic [7:0] tok [$];
		logic [kwm_pkg::CFG_DATA_W-1:0] nm;
		logic [7:0] c;
		int kind;
		int n_args;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 6))
				add_sym(8'($urandom_range(0, 255)));
			return;
		end
		if (kind <= 6) begin
			nm = cfg_names[$urandom_range(0, NAME_SLOTS - 1)];
			for (int i = 0; i < NAME_BYTES && nm[8*i +: 8] != '0; i++)
				tok.insert(tok.size(), nm[8*i +: 8]);
		end else begin
			repeat ($urandom_range(0, 10))
				tok.insert(tok.size(), name_symbol());
		end
		case ($urandom_range(0, 11))
			0: begin
				if (tok.size() != 0)
					void'(tok.pop_back());
			end
			1: tok.insert(tok.size(), name_symbol());
			2: begin
				if (tok.size() != 0)
					tok[$urandom_range(0, tok.size() - 1)] = name_symbol();
			end
			3: tok.insert($urandom_range(0, tok.size()), 8'h00);
			4: tok.insert($urandom_range(0, tok.size()), kwm_pkg::SYM_RETURN);
			default: ;
		endcase
		foreach (tok[i])
			add_sym(tok[i]);
		if ($urandom_range(0, 2) == 0) begin
			add_sym(kwm_pkg::SYM_SPACE);
			// now and then a long line that can overflow even the widest limit
			n_args = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 12);
			repeat (n_args) begin
				c = 8'($urandom_range(0, 255));
				if (c == kwm_pkg::SYM_NEWLINE)
					c = kwm_pkg::SYM_SPACE;
				add_sym(c);
			end
		end
		add_sym(kwm_pkg::SYM_NEWLINE);
	endfunction

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sym_ch.valid = 1'b0;
		sym_ch.symbol = '0;
		res_ch.ready = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		sym_gap_max = 0;
		res_gap_max = 0;
		cfg_max_len = kwm_pkg::MAX_LEN_RESET;
		foreach (cfg_names[i])
			cfg_names[i] = '0;
		clear_line();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset names are all empty, so even odd bytes are unknown.
		add_sym(8'h00);
		add_sym(8'hFF);
		add_sym(kwm_pkg::SYM_NEWLINE);
		wait_drained();

		// Tight limit, duplicate names: lowest slot wins, CR is ignored,
		// then a line that runs past the limit.
		write_reg(kwm_pkg::REG_MAX_LEN, kwm_pkg::CFG_DATA_W'(3));
		write_reg(kwm_pkg::REG_NAME_BASE, 64'h6261);         // "ab"
		write_reg(kwm_pkg::CFG_INDEX_W'(int'(kwm_pkg::REG_NAME_BASE) + 1),
			64'h6261);                                          // "ab" again
		queue_text("ab\r\n");
		queue_text("abcde\n");
		wait_drained();

		// Widest limit and a name that fills all eight bytes.
		write_reg(kwm_pkg::REG_MAX_LEN, kwm_pkg::CFG_DATA_W'(255));
		write_reg(kwm_pkg::CFG_INDEX_W'(int'(kwm_pkg::REG_NAME_BASE) + 2),
			64'h6867_6665_6463_6261);                           // "abcdefgh"
		queue_text("abcdefgh\n");
		wait_drained();

		// Random phases; each one ends with the sender drained, which is also
		// where registers change.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin sym_gap_max = 9; res_gap_max = 9; end
				1: begin sym_gap_max = 0; res_gap_max = 9; end
				2: begin sym_gap_max = 9; res_gap_max = 0; end
				default: begin sym_gap_max = 0; res_gap_max = 0; end
			endcase
			if (ph == 0)
				write_reg(kwm_pkg::REG_MAX_LEN, kwm_pkg::CFG_DATA_W'(0));
			else if (ph == 1)
				write_reg(kwm_pkg::REG_MAX_LEN, kwm_pkg::CFG_DATA_W'(255));
			else if ($urandom_range(0, 1) == 0)
				write_reg(kwm_pkg::REG_MAX_LEN, kwm_pkg::CFG_DATA_W'($urandom_range(0, 255)));
			else
				write_reg(kwm_pkg::REG_MAX_LEN, kwm_pkg::CFG_DATA_W'($urandom_range(4, 24)));
			for (int s = 0; s < kwm_pkg::REG_SLOTS; s++) begin
				if (ph == 0 || $urandom_range(0, 2) == 0)
					write_reg(kwm_pkg::CFG_INDEX_W'(int'(kwm_pkg::REG_NAME_BASE) + s),
						make_name());
			end
			while (sym_pending.size() < PHASE_ITEMS)
				queue_line();
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/kwm_pkg.sv
rtl/kwm_if.sv
rtl/kwm_cfg.sv
rtl/kwm_line.sv
rtl/command_line_keyword_matcher.sv
rtl/kwm_checker.sv
bench/tb_top.sv
